// ----- hw/rtl/byte_stream_mode_finder_core_macros.svh -----
// Assertion macros for the byte stream mode finder.
`ifndef BYTE_STREAM_MODE_FINDER_CORE_MACROS_SVH
`define BYTE_STREAM_MODE_FINDER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, held off while reset is high.
`define BSMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bsmf assertion failed");
// Clocked check that also holds through reset.
`define BSMF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bsmf assertion failed");
`else
`define BSMF_ASSERT(lbl, prop)
`define BSMF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/bsmf_pkg.sv -----
// Shared constants and types for the byte stream mode finder.
`timescale 1ns / 1ps
package bsmf_pkg;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int BYTE_W           = 8;
  localparam int OUT_COUNT_W      = 16;

  // Control of the count stage.
  typedef struct packed {
    logic valid;  // stage holds a beat
    logic last;   // beat closes the string
    logic hit;    // code falls inside the histogram
  } bsmf_ctl_t;
endpackage

// ----- hw/rtl/byte_stream_mode_finder_core.sv -----
// Top level of the byte stream mode finder.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, byte_value, end_of_string | in
//   output  | out_valid, out_ready, mode_byte, mode_count   | out
//
// One byte per cycle sustained; a histogram read is issued on the accepted
// beat and the read-modify-write closes in the next cycle, the write of the
// previous beat forwarded. A result registers as its final byte leaves s1.
// Reset clears the entry valid bits at once, so no clearing pass is needed;
// the histogram is likewise dropped in the cycle a string ends.
// in_ready falls only while a final byte waits behind an untaken result.
`timescale 1ns / 1ps
`include "byte_stream_mode_finder_core_macros.svh"
module byte_stream_mode_finder_core import bsmf_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      byte_value,
  input  logic                   end_of_string,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      mode_byte,
  output logic [OUT_COUNT_W-1:0] mode_count
);
  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam logic [BYTE_W:0] SYM_LIMIT = (BYTE_W + 1)'(SYMBOL_COUNT);
  localparam logic [31:0] OUT_MAX = 32'((64'd1 << OUT_COUNT_W) - 64'd1);

  bsmf_ctl_t             s1_ctl;
  logic [BYTE_W-1:0]     s1_code;
  logic                  stall;
  logic                  advance;
  logic                  accept;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] rd_data;
  logic [BYTE_W-1:0]     res_symbol;
  logic [COUNT_BITS-1:0] res_count;
  logic [31:0]           res_wide;

  // Hold the final beat while the previous result is still untaken.
  assign stall    = s1_ctl.valid && s1_ctl.last && out_valid && !out_ready;
  assign advance  = !stall;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (advance) begin
      s1_ctl.valid <= accept;
      s1_ctl.last  <= end_of_string;
      s1_ctl.hit   <= ({1'b0, byte_value} < SYM_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_code <= byte_value;
    end
  end

  bsmf_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SYMBOL_COUNT)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (byte_value[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  bsmf_update #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ctl        (s1_ctl),
    .code       (s1_code),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .res_symbol (res_symbol),
    .res_count  (res_count)
  );

  assign res_wide = 32'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_ctl.valid && s1_ctl.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_ctl.valid && s1_ctl.last) begin
      mode_byte  <= res_symbol;
      mode_count <= (res_wide > OUT_MAX) ? OUT_MAX[OUT_COUNT_W-1:0]
                                         : res_wide[OUT_COUNT_W-1:0];
    end
  end

  `BSMF_ASSERT(a_ready_only_on_result_stall, !in_ready |-> (out_valid && !out_ready))
  `BSMF_ASSERT(a_result_follows_last, $rose(out_valid) |-> $past(s1_ctl.valid && s1_ctl.last))
  `BSMF_ASSERT(a_empty_string_code_zero, (out_valid && mode_count == '0) |-> (mode_byte == '0))
  `BSMF_ASSERT_ALWAYS(a_no_write_on_last, wr_en |-> (s1_ctl.valid && !s1_ctl.last && !rst))
endmodule

// ----- hw/rtl/bsmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bsmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- hw/rtl/bsmf_update.sv -----
// Count stage: forwarding, saturating increment, entry valid bits and best tracking.
`timescale 1ns / 1ps
module bsmf_update import bsmf_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  localparam int ADDR_W = $clog2(SYMBOL_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  bsmf_ctl_t             ctl,
  input  logic [BYTE_W-1:0]     code,
  input  logic [COUNT_BITS-1:0] rd_data,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [COUNT_BITS-1:0] wr_data,
  output logic [BYTE_W-1:0]     res_symbol,
  output logic [COUNT_BITS-1:0] res_count
);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [SYMBOL_COUNT-1:0] entry_valid;
  logic                    fwd_valid;
  logic [ADDR_W-1:0]       fwd_addr;
  logic [COUNT_BITS-1:0]   fwd_data;
  logic [BYTE_W-1:0]       best_symbol;
  logic [COUNT_BITS-1:0]   best_count;

  logic [ADDR_W-1:0]     addr;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  take;
  logic [BYTE_W-1:0]     best_symbol_next;
  logic [COUNT_BITS-1:0] best_count_next;

  always_comb begin
    addr = code[ADDR_W-1:0];
    // The write of the previous beat is not yet visible in the read data.
    if (fwd_valid && fwd_addr == addr) begin
      old_count = fwd_data;
    end else if (entry_valid[addr]) begin
      old_count = rd_data;
    end else begin
      old_count = '0;
    end
    new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
    take = ctl.hit && ((new_count > best_count) ||
                       (new_count == best_count && code < best_symbol));
    best_symbol_next = take ? code : best_symbol;
    best_count_next  = take ? new_count : best_count;
  end

  assign wr_en      = advance && ctl.valid && ctl.hit && !ctl.last;
  assign wr_addr    = addr;
  assign wr_data    = new_count;
  assign res_symbol = best_symbol_next;
  assign res_count  = best_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fwd_valid   <= 1'b0;
      best_symbol <= '0;
      best_count  <= '0;
    end else if (advance) begin
      fwd_valid <= wr_en;
      if (ctl.valid && ctl.last) begin
        // Drop the whole histogram for the next string.
        entry_valid <= '0;
        best_symbol <= '0;
        best_count  <= '0;
      end else if (ctl.valid) begin
        if (wr_en) begin
          entry_valid[addr] <= 1'b1;
        end
        best_symbol <= best_symbol_next;
        best_count  <= best_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_addr <= addr;
      fwd_data <= new_count;
    end
  end
endmodule
